// File: hw/rtl/tda_pkg.sv
package tda_pkg;

  localparam logic [16:0] DAY_SEC     = 17'd86400;
  localparam logic [16:0] HOUR_SEC    = 17'd3600;
  localparam logic [5:0]  MIN_SEC     = 6'd60;
  localparam logic [4:0]  MAX_HOUR    = 5'd23;
  localparam logic [5:0]  MAX_MIN_SEC = 6'd59;
  localparam int          NUM_HOURS   = 24;

  // 86400 = 128 * 675: the low seven bits pass through, the rest is divided by 675.
  localparam int          DAY_LOW_BITS = 7;
  localparam logic [9:0]  DAY_ODD      = 10'd675;
  localparam logic [25:0] DAY_RECIP    = 26'd50903317;
  localparam int          DAY_SHIFT    = 35;

  // Minute of the hour: (rem / 4) / 15 through a reciprocal.
  localparam logic [10:0] MIN_RECIP = 11'd1093;
  localparam int          MIN_SHIFT = 14;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_SUB     = 3'd1,
    OP_DUR     = 3'd2,
    OP_TO_SEC  = 3'd3,
    OP_TO_TIME = 3'd4
  } tda_op_t;

  typedef struct packed {
    logic less;
    logic equal;
    logic greater;
  } tda_cmp_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } tda_adv_t;

  function automatic logic [16:0] tda_day_raw(input logic [4:0] h, input logic [5:0] m,
                                              input logic [5:0] s);
    logic [16:0] acc;
    acc = 17'(h) * HOUR_SEC + 17'(m) * 17'(MIN_SEC) + 17'(s);
    return acc;
  endfunction

  function automatic logic tda_time_ok(input logic [4:0] h, input logic [5:0] m,
                                       input logic [5:0] s);
    return (h <= MAX_HOUR) && (m <= MAX_MIN_SEC) && (s <= MAX_MIN_SEC);
  endfunction

endpackage

// File: hw/rtl/tda_prep.sv
module tda_prep (
  input  logic             clk,
  input  tda_pkg::tda_adv_t adv,
  input  logic [2:0]       op,
  input  logic [4:0]       hour_a,
  input  logic [5:0]       minute_a,
  input  logic [5:0]       second_a,
  input  logic [4:0]       hour_b,
  input  logic [5:0]       minute_b,
  input  logic [5:0]       second_b,
  input  logic [31:0]      count_seconds,
  output logic [2:0]       op_r,
  output tda_pkg::tda_cmp_t cmp_r,
  output logic             va_r,
  output logic             vb_r,
  output logic [16:0]      raw_a_r,
  output logic [16:0]      raw_b_r,
  output logic [24:0]      n_hi_r,
  output logic [6:0]       n_lo_r,
  output logic [15:0]      quot_r
);
  import tda_pkg::*;

  logic [16:0]   key_a;
  logic [16:0]   key_b;
  logic [50:0]   prod;
  tda_cmp_t      cmp_nxt;

  assign key_a = {hour_a, minute_a, second_a};
  assign key_b = {hour_b, minute_b, second_b};
  assign prod  = 51'(count_seconds[31:DAY_LOW_BITS]) * 51'(DAY_RECIP);

  always_comb begin
    cmp_nxt.less    = key_a < key_b;
    cmp_nxt.equal   = key_a == key_b;
    cmp_nxt.greater = key_a > key_b;
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      op_r    <= op;
      cmp_r   <= cmp_nxt;
      va_r    <= tda_time_ok(hour_a, minute_a, second_a);
      vb_r    <= tda_time_ok(hour_b, minute_b, second_b);
      raw_a_r <= tda_day_raw(hour_a, minute_a, second_a);
      raw_b_r <= tda_day_raw(hour_b, minute_b, second_b);
      n_hi_r  <= count_seconds[31:DAY_LOW_BITS];
      n_lo_r  <= count_seconds[DAY_LOW_BITS-1:0];
      quot_r  <= prod[DAY_SHIFT +: 16];
    end
  end

endmodule

// File: hw/rtl/tda_reduce.sv
module tda_reduce (
  input  logic             clk,
  input  tda_pkg::tda_adv_t adv,
  input  logic [2:0]       op,
  input  tda_pkg::tda_cmp_t cmp,
  input  logic             va,
  input  logic             vb,
  input  logic [16:0]      raw_a,
  input  logic [16:0]      raw_b,
  input  logic [24:0]      n_hi,
  input  logic [6:0]       n_lo,
  input  logic [15:0]      quot,
  output logic [2:0]       op_r,
  output tda_pkg::tda_cmp_t cmp_r,
  output logic             va_r,
  output logic             vb_r,
  output logic [16:0]      sec_a_r,
  output logic [16:0]      sec_b_r,
  output logic [16:0]      n_mod_r
);
  import tda_pkg::*;

  logic [25:0] quot_prod;
  logic [9:0]  n_rem;

  assign quot_prod = 26'(quot) * 26'(DAY_ODD);
  assign n_rem     = 10'(26'(n_hi) - quot_prod);

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      op_r    <= op;
      cmp_r   <= cmp;
      va_r    <= va;
      vb_r    <= vb;
      sec_a_r <= (raw_a >= DAY_SEC) ? raw_a - DAY_SEC : raw_a;
      sec_b_r <= (raw_b >= DAY_SEC) ? raw_b - DAY_SEC : raw_b;
      n_mod_r <= {n_rem, n_lo};
    end
  end

endmodule

// File: hw/rtl/tda_select.sv
module tda_select (
  input  logic             clk,
  input  tda_pkg::tda_adv_t adv,
  input  logic [2:0]       op,
  input  tda_pkg::tda_cmp_t cmp,
  input  logic             va,
  input  logic             vb,
  input  logic [16:0]      sec_a,
  input  logic [16:0]      sec_b,
  input  logic [16:0]      n_mod,
  output tda_pkg::tda_cmp_t cmp_r,
  output logic             tv_r,
  output logic [16:0]      res_r
);
  import tda_pkg::*;

  logic [17:0] sum_an;
  logic [16:0] add_res;
  logic [16:0] sub_res;
  logic [16:0] dur_res;
  logic [16:0] res_nxt;
  logic        tv_nxt;

  assign sum_an  = 18'(sec_a) + 18'(n_mod);
  assign add_res = (sum_an >= 18'(DAY_SEC)) ? 17'(sum_an - 18'(DAY_SEC)) : 17'(sum_an);
  assign sub_res = (sec_a >= n_mod) ? sec_a - n_mod : 17'(18'(sec_a) + 18'(DAY_SEC)
                   - 18'(n_mod));
  assign dur_res = (sec_b >= sec_a) ? sec_b - sec_a : 17'(18'(sec_b) + 18'(DAY_SEC)
                   - 18'(sec_a));

  always_comb begin
    unique case (tda_op_t'(op))
      OP_ADD: begin
        res_nxt = add_res;
        tv_nxt  = va;
      end
      OP_SUB: begin
        res_nxt = sub_res;
        tv_nxt  = va;
      end
      OP_DUR: begin
        res_nxt = dur_res;
        tv_nxt  = va && vb;
      end
      OP_TO_SEC: begin
        res_nxt = sec_a;
        tv_nxt  = va;
      end
      OP_TO_TIME: begin
        res_nxt = n_mod;
        tv_nxt  = 1'b1;
      end
      default: begin
        res_nxt = '0;
        tv_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      cmp_r <= cmp;
      tv_r  <= tv_nxt;
      res_r <= res_nxt;
    end
  end

endmodule

// File: hw/rtl/tda_split.sv
module tda_split (
  input  logic             clk,
  input  tda_pkg::tda_adv_t adv,
  input  tda_pkg::tda_cmp_t cmp,
  input  logic             tv,
  input  logic [16:0]      res,
  output logic [4:0]       hour_r,
  output logic [5:0]       minute_r,
  output logic [5:0]       second_r,
  output logic [16:0]      seconds_r,
  output tda_pkg::tda_cmp_t cmp_r,
  output logic             tv_r
);
  import tda_pkg::*;

  logic [4:0]  hour_nxt;
  logic [16:0] base;
  logic [4:0]  hour5_r;
  logic [11:0] rem5_r;
  logic [16:0] secs5_r;
  tda_cmp_t    cmp5_r;
  logic        tv5_r;
  logic [20:0] min_prod;
  logic [5:0]  minute_nxt;
  logic [11:0] minute_sec;

  // The hour is found by comparing against every whole-hour boundary.
  always_comb begin
    hour_nxt = '0;
    base     = '0;
    for (int k = 1; k < NUM_HOURS; k++) begin
      if (res >= 17'(k * int'(HOUR_SEC))) begin
        hour_nxt = 5'(k);
        base     = 17'(k * int'(HOUR_SEC));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s5) begin
      hour5_r <= hour_nxt;
      rem5_r  <= 12'(res - base);
      secs5_r <= res;
      cmp5_r  <= cmp;
      tv5_r   <= tv;
    end
  end

  assign min_prod   = 21'(rem5_r[11:2]) * 21'(MIN_RECIP);
  assign minute_nxt = min_prod[MIN_SHIFT +: 6];
  assign minute_sec = (12'(minute_nxt) << 6) - (12'(minute_nxt) << 2);

  always_ff @(posedge clk) begin
    if (adv.s6) begin
      hour_r    <= hour5_r;
      minute_r  <= minute_nxt;
      second_r  <= 6'(rem5_r - minute_sec);
      seconds_r <= secs5_r;
      cmp_r     <= cmp5_r;
      tv_r      <= tv5_r;
    end
  end

endmodule

// File: hw/rtl/time_of_day_arithmetic_unit_top.sv
// Throughput: one transfer per cycle unless the output stalls, through a
// six-register pipeline whose longest step is the 25 by 26 bit reciprocal
// multiply that reduces the count.
// A stalled result holds its stage; earlier stages keep filling any bubbles.
// Reset clears the stage valid bits only; the data registers are not reset.
module time_of_day_arithmetic_unit_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // operation, hour_a, minute_a, second_a, hour_b, minute_b, second_b, count_seconds
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // hour_out, minute_out, second_out, seconds_out, a_less, a_equal, a_greater
  output logic [39:0] out_tdata,
  // times_valid
  output logic        out_tuser
);
  import tda_pkg::*;

  tda_adv_t    adv;
  logic [6:1]  vld_r;
  logic [6:1]  vld_nxt;

  logic [2:0]  op1_r;
  logic [4:0]  hour_a1_r;
  logic [5:0]  minute_a1_r;
  logic [5:0]  second_a1_r;
  logic [4:0]  hour_b1_r;
  logic [5:0]  minute_b1_r;
  logic [5:0]  second_b1_r;
  logic [31:0] count1_r;

  logic [2:0]  op2;
  tda_cmp_t    cmp2;
  logic        va2;
  logic        vb2;
  logic [16:0] raw_a2;
  logic [16:0] raw_b2;
  logic [24:0] n_hi2;
  logic [6:0]  n_lo2;
  logic [15:0] quot2;

  logic [2:0]  op3;
  tda_cmp_t    cmp3;
  logic        va3;
  logic        vb3;
  logic [16:0] sec_a3;
  logic [16:0] sec_b3;
  logic [16:0] n_mod3;

  tda_cmp_t    cmp4;
  logic        tv4;
  logic [16:0] res4;

  logic [4:0]  hour6;
  logic [5:0]  minute6;
  logic [5:0]  second6;
  logic [16:0] seconds6;
  tda_cmp_t    cmp6;
  logic        tv6;

  always_comb begin
    adv.s6 = !vld_r[6] || out_tready;
    adv.s5 = !vld_r[5] || adv.s6;
    adv.s4 = !vld_r[4] || adv.s5;
    adv.s3 = !vld_r[3] || adv.s4;
    adv.s2 = !vld_r[2] || adv.s3;
    adv.s1 = !vld_r[1] || adv.s2;
  end

  assign in_tready = adv.s1;

  always_comb begin
    vld_nxt[1] = adv.s1 ? in_tvalid : vld_r[1];
    vld_nxt[2] = adv.s2 ? vld_r[1]  : vld_r[2];
    vld_nxt[3] = adv.s3 ? vld_r[2]  : vld_r[3];
    vld_nxt[4] = adv.s4 ? vld_r[3]  : vld_r[4];
    vld_nxt[5] = adv.s5 ? vld_r[4]  : vld_r[5];
    vld_nxt[6] = adv.s6 ? vld_r[5]  : vld_r[6];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      op1_r       <= in_tdata[2:0];
      hour_a1_r   <= in_tdata[7:3];
      minute_a1_r <= in_tdata[13:8];
      second_a1_r <= in_tdata[19:14];
      hour_b1_r   <= in_tdata[24:20];
      minute_b1_r <= in_tdata[30:25];
      second_b1_r <= in_tdata[36:31];
      count1_r    <= in_tdata[68:37];
    end
  end

  tda_prep u_prep (
    .clk           (clk),
    .adv           (adv),
    .op            (op1_r),
    .hour_a        (hour_a1_r),
    .minute_a      (minute_a1_r),
    .second_a      (second_a1_r),
    .hour_b        (hour_b1_r),
    .minute_b      (minute_b1_r),
    .second_b      (second_b1_r),
    .count_seconds (count1_r),
    .op_r          (op2),
    .cmp_r         (cmp2),
    .va_r          (va2),
    .vb_r          (vb2),
    .raw_a_r       (raw_a2),
    .raw_b_r       (raw_b2),
    .n_hi_r        (n_hi2),
    .n_lo_r        (n_lo2),
    .quot_r        (quot2)
  );

  tda_reduce u_reduce (
    .clk     (clk),
    .adv     (adv),
    .op      (op2),
    .cmp     (cmp2),
    .va      (va2),
    .vb      (vb2),
    .raw_a   (raw_a2),
    .raw_b   (raw_b2),
    .n_hi    (n_hi2),
    .n_lo    (n_lo2),
    .quot    (quot2),
    .op_r    (op3),
    .cmp_r   (cmp3),
    .va_r    (va3),
    .vb_r    (vb3),
    .sec_a_r (sec_a3),
    .sec_b_r (sec_b3),
    .n_mod_r (n_mod3)
  );

  tda_select u_select (
    .clk   (clk),
    .adv   (adv),
    .op    (op3),
    .cmp   (cmp3),
    .va    (va3),
    .vb    (vb3),
    .sec_a (sec_a3),
    .sec_b (sec_b3),
    .n_mod (n_mod3),
    .cmp_r (cmp4),
    .tv_r  (tv4),
    .res_r (res4)
  );

  tda_split u_split (
    .clk       (clk),
    .adv       (adv),
    .cmp       (cmp4),
    .tv        (tv4),
    .res       (res4),
    .hour_r    (hour6),
    .minute_r  (minute6),
    .second_r  (second6),
    .seconds_r (seconds6),
    .cmp_r     (cmp6),
    .tv_r      (tv6)
  );

  assign out_tvalid = vld_r[6];
  assign out_tdata  = {3'b000, cmp6.greater, cmp6.equal, cmp6.less, seconds6, second6,
                       minute6, hour6};
  assign out_tuser  = tv6;

  a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[4:0] <= MAX_HOUR))
    else $error("hour of a result is beyond the last hour of the day");

  a_split_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (17'(out_tdata[4:0]) * HOUR_SEC + 17'(out_tdata[10:5]) * 17'(MIN_SEC)
                    + 17'(out_tdata[16:11]) == out_tdata[33:17]))
    else $error("hour, minute and second disagree with the seconds count");

  a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot(out_tdata[36:34]))
    else $error("comparison flags are not exactly one");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled although the result stage is empty");

endmodule
